### design/bfpa_pkg.sv
// shared types, constants and defaults for the best-fit page allocator
// no dependencies
`timescale 1ns / 1ps

package bfpa_pkg;

  localparam int ADDR_W  = 32;
  localparam int PAGES_W = 18;
  localparam int ENTRY_W = ADDR_W + PAGES_W;

  localparam logic [PAGES_W-1:0] PAGES_MAX = '1;

  localparam int          DEF_PAGE_BYTES   = 4096;
  localparam logic [31:0] DEF_HEAP_BASE    = 32'h8000_0000;
  localparam logic [31:0] DEF_HEAP_LIMIT   = 32'hA000_0000;
  localparam int          DEF_HOLE_SLOTS   = 64;
  localparam int          DEF_RECORD_SLOTS = 64;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NO_SPACE = 2'd1;
  localparam status_t ST_UNKNOWN  = 2'd2;
  localparam status_t ST_REC_FULL = 2'd3;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

endpackage

### design/bfpa_if.sv
// valid/ready channel interfaces for requests and results
// depends on bfpa_pkg
`timescale 1ns / 1ps

interface bfpa_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [bfpa_pkg::ADDR_W-1:0]  size_bytes;
  logic [bfpa_pkg::ADDR_W-1:0]  block_address;
  modport source (output valid, action, size_bytes, block_address, input ready);
  modport sink   (input valid, action, size_bytes, block_address, output ready);
endinterface

interface bfpa_out_if;
  logic                         valid;
  logic                         ready;
  bfpa_pkg::status_t            status;
  logic [bfpa_pkg::ADDR_W-1:0]  granted_address;
  logic [bfpa_pkg::PAGES_W-1:0] page_count;
  modport source (output valid, status, granted_address, page_count, input ready);
  modport sink   (input valid, status, granted_address, page_count, output ready);
endinterface

### design/bfpa_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bfpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/best_fit_page_allocator_top.sv
// Best-fit page allocator. Each request transfer either allocates (rounded up
// to whole pages, smallest fitting hole first, else bump of the top pointer
// while the space above it is strictly larger) or releases a block by its
// start address (top blocks lower the top pointer, others become holes that
// coalesce with their neighbors, or are dropped when no hole slot is free).
// One result transfer per request. A small sequencer walks the record and
// hole tables one entry at a time through rams with separate write and read
// ports and registered reads: an allocate scans the records for a free slot,
// then every hole; a release scans the records for the address, then, unless
// the block is on top, every hole for neighbors. No new request is taken
// until the previous one is finished, while a finished result may wait in
// the output register. Valid bits of both tables are cleared by reset.
// depends on bfpa_pkg, bfpa_if, bfpa_ram
`timescale 1ns / 1ps

module best_fit_page_allocator_top #(
  parameter int          PAGE_BYTES   = bfpa_pkg::DEF_PAGE_BYTES,
  parameter logic [31:0] HEAP_BASE    = bfpa_pkg::DEF_HEAP_BASE,
  parameter logic [31:0] HEAP_LIMIT   = bfpa_pkg::DEF_HEAP_LIMIT,
  parameter int          HOLE_SLOTS   = bfpa_pkg::DEF_HOLE_SLOTS,
  parameter int          RECORD_SLOTS = bfpa_pkg::DEF_RECORD_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  bfpa_in_if.sink     in_ch,
  bfpa_out_if.source  out_ch
);

  localparam int AW  = bfpa_pkg::ADDR_W;
  localparam int PW  = bfpa_pkg::PAGES_W;
  localparam int EW  = bfpa_pkg::ENTRY_W;
  localparam int SH  = $clog2(PAGE_BYTES);
  localparam int HW  = $clog2(HOLE_SLOTS);
  localparam int RW  = $clog2(RECORD_SLOTS);
  localparam int MAXS = (HOLE_SLOTS > RECORD_SLOTS) ? HOLE_SLOTS : RECORD_SLOTS;
  localparam int CW  = $clog2(MAXS) + 1;
  // wide enough for address plus a block span
  localparam int SW  = ((PW + SH > AW) ? PW + SH : AW) + 1;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RSCAN = 4'd1;   // alloc: find free record slot
  localparam logic [3:0] S_HRD   = 4'd2;   // alloc: read hole entry
  localparam logic [3:0] S_HCK   = 4'd3;   // alloc: best-fit compare
  localparam logic [3:0] S_AFIN  = 4'd4;   // alloc: commit
  localparam logic [3:0] S_RRD   = 4'd5;   // release: read record entry
  localparam logic [3:0] S_RCK   = 4'd6;   // release: match address
  localparam logic [3:0] S_RFIN  = 4'd7;   // release: top check
  localparam logic [3:0] S_PRD   = 4'd8;   // release: read hole entry
  localparam logic [3:0] S_PCK   = 4'd9;   // release: neighbor search
  localparam logic [3:0] S_MERGE = 4'd10;  // release: coalesce / insert
  localparam logic [3:0] S_OUT   = 4'd11;  // hand result to output register

  logic [3:0]    state_r;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] np_r;
  logic [AW-1:0] addr_r;
  logic [AW-1:0] top_r;
  logic [RW-1:0] rslot_r;

  logic          best_f_r;
  logic [HW-1:0] best_idx_r;
  logic [AW-1:0] best_start_r;
  logic [PW-1:0] best_pages_r;

  logic          pred_f_r, succ_f_r, free_f_r;
  logic [HW-1:0] pred_idx_r, succ_idx_r, free_idx_r;
  logic [AW-1:0] pred_start_r;
  logic [PW-1:0] pred_pages_r, succ_pages_r;

  logic [HOLE_SLOTS-1:0]   hv_r;
  logic [RECORD_SLOTS-1:0] rv_r;

  bfpa_pkg::status_t res_status_r;
  logic [AW-1:0]     res_addr_r;
  logic [PW-1:0]     res_pages_r;

  logic              out_valid_r;
  bfpa_pkg::status_t out_status_r;
  logic [AW-1:0]     out_addr_r;
  logic [PW-1:0]     out_pages_r;

  // ram ports
  logic          h_we, r_we;
  logic [HW-1:0] h_waddr;
  logic [RW-1:0] r_waddr;
  logic [EW-1:0] h_wdata, r_wdata, h_rdata, r_rdata;
  logic [HW-1:0] h_idx;
  logic [RW-1:0] r_idx;

  assign h_idx = cnt_r[HW-1:0];
  assign r_idx = cnt_r[RW-1:0];

  bfpa_ram #(.WIDTH(EW), .DEPTH(HOLE_SLOTS)) u_hole_ram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_idx), .rdata(h_rdata)
  );

  bfpa_ram #(.WIDTH(EW), .DEPTH(RECORD_SLOTS)) u_rec_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_idx), .rdata(r_rdata)
  );

  // entry fields from ram
  logic [AW-1:0] h_start, r_start;
  logic [PW-1:0] h_pages, r_pages;
  assign h_start = h_rdata[EW-1:PW];
  assign h_pages = h_rdata[PW-1:0];
  assign r_start = r_rdata[EW-1:PW];
  assign r_pages = r_rdata[PW-1:0];

  // span and end arithmetic
  logic [SW-1:0] np_span, blk_end, h_end, top_ext, avail, lim_ext;
  assign np_span = SW'(np_r) << SH;
  assign blk_end = SW'(addr_r) + np_span;
  assign h_end   = SW'(h_start) + (SW'(h_pages) << SH);
  assign top_ext = SW'(top_r);
  assign lim_ext = SW'(HEAP_LIMIT);
  assign avail   = (lim_ext > top_ext) ? lim_ext - top_ext : '0;

  // size rounding on the request transfer
  logic [AW:0] round_sum, pages_full;
  assign round_sum  = {1'b0, in_ch.size_bytes} + (AW+1)'(PAGE_BYTES - 1);
  assign pages_full = round_sum >> SH;

  // merge sums
  logic [PW:0]   pred_sum, succ_sum;
  logic [PW+1:0] tri_sum;
  logic          pred_ok, tri_ok, succ_ok;
  assign pred_sum = {1'b0, pred_pages_r} + {1'b0, np_r};
  assign succ_sum = {1'b0, succ_pages_r} + {1'b0, np_r};
  assign tri_sum  = {1'b0, pred_sum} + (PW+2)'(succ_pages_r);
  assign pred_ok  = pred_f_r && (pred_sum <= (PW+1)'(bfpa_pkg::PAGES_MAX));
  assign tri_ok   = succ_f_r && (tri_sum <= (PW+2)'(bfpa_pkg::PAGES_MAX));
  assign succ_ok  = succ_f_r && (succ_sum <= (PW+1)'(bfpa_pkg::PAGES_MAX));

  logic last_h, last_r;
  assign last_h = (cnt_r == CW'(HOLE_SLOTS - 1));
  assign last_r = (cnt_r == CW'(RECORD_SLOTS - 1));

  // ram write decode
  always_comb begin
    h_we    = 1'b0;
    h_waddr = best_idx_r;
    h_wdata = {AW'(SW'(best_start_r) + np_span), best_pages_r - np_r};
    r_we    = 1'b0;
    r_waddr = rslot_r;
    r_wdata = {(best_f_r ? best_start_r : top_r), np_r};
    unique case (state_r)
      S_AFIN: begin
        if (best_f_r) begin
          h_we = (best_pages_r != np_r);
          r_we = 1'b1;
        end else begin
          r_we = (avail > np_span);
        end
      end
      S_MERGE: begin
        if (pred_ok) begin
          h_we    = 1'b1;
          h_waddr = pred_idx_r;
          h_wdata = {pred_start_r, tri_ok ? tri_sum[PW-1:0] : pred_sum[PW-1:0]};
        end else if (succ_ok) begin
          h_we    = 1'b1;
          h_waddr = succ_idx_r;
          h_wdata = {addr_r, succ_sum[PW-1:0]};
        end else begin
          h_we    = free_f_r;
          h_waddr = free_idx_r;
          h_wdata = {addr_r, np_r};
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.granted_address = out_addr_r;
  assign out_ch.page_count      = out_pages_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= HEAP_BASE;
      hv_r        <= '0;
      rv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output register drains on a result transfer, unless refilled below
      if (out_valid_r && out_ch.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            addr_r       <= in_ch.block_address;
            np_r         <= pages_full[PW-1:0];
            cnt_r        <= '0;
            res_status_r <= bfpa_pkg::ST_OK;
            res_addr_r   <= '0;
            res_pages_r  <= '0;
            best_f_r     <= 1'b0;
            if (in_ch.action == bfpa_pkg::ACT_RELEASE) begin
              state_r <= S_RRD;
            end else if (in_ch.size_bytes == '0 ||
                         pages_full > (AW+1)'(bfpa_pkg::PAGES_MAX)) begin
              res_status_r <= bfpa_pkg::ST_NO_SPACE;
              state_r      <= S_OUT;
            end else begin
              state_r <= S_RSCAN;
            end
          end
        end
        S_RSCAN: begin
          if (!rv_r[r_idx]) begin
            rslot_r <= r_idx;
            cnt_r   <= '0;
            state_r <= S_HRD;
          end else if (last_r) begin
            res_status_r <= bfpa_pkg::ST_REC_FULL;
            state_r      <= S_OUT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_HRD: state_r <= S_HCK;
        S_HCK: begin
          if (hv_r[h_idx] && h_pages >= np_r &&
              (!best_f_r || h_pages < best_pages_r)) begin
            best_f_r     <= 1'b1;
            best_idx_r   <= h_idx;
            best_start_r <= h_start;
            best_pages_r <= h_pages;
          end
          if (last_h) begin
            state_r <= S_AFIN;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_HRD;
          end
        end
        S_AFIN: begin
          state_r <= S_OUT;
          if (best_f_r) begin
            if (best_pages_r == np_r) begin
              hv_r[best_idx_r] <= 1'b0;
            end
            rv_r[rslot_r] <= 1'b1;
            res_addr_r    <= best_start_r;
            res_pages_r   <= np_r;
          end else if (avail > np_span) begin
            top_r         <= AW'(top_ext + np_span);
            rv_r[rslot_r] <= 1'b1;
            res_addr_r    <= top_r;
            res_pages_r   <= np_r;
          end else begin
            res_status_r <= bfpa_pkg::ST_NO_SPACE;
          end
        end
        S_RRD: state_r <= S_RCK;
        S_RCK: begin
          if (rv_r[r_idx] && r_start == addr_r) begin
            rslot_r <= r_idx;
            np_r    <= r_pages;
            state_r <= S_RFIN;
          end else if (last_r) begin
            res_status_r <= bfpa_pkg::ST_UNKNOWN;
            state_r      <= S_OUT;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_RRD;
          end
        end
        S_RFIN: begin
          rv_r[rslot_r] <= 1'b0;
          res_addr_r    <= addr_r;
          res_pages_r   <= np_r;
          cnt_r         <= '0;
          pred_f_r      <= 1'b0;
          succ_f_r      <= 1'b0;
          free_f_r      <= 1'b0;
          if (blk_end == top_ext) begin
            top_r   <= addr_r;
            state_r <= S_OUT;
          end else begin
            state_r <= S_PRD;
          end
        end
        S_PRD: state_r <= S_PCK;
        S_PCK: begin
          if (hv_r[h_idx]) begin
            if (!pred_f_r && h_end == SW'(addr_r)) begin
              pred_f_r     <= 1'b1;
              pred_idx_r   <= h_idx;
              pred_start_r <= h_start;
              pred_pages_r <= h_pages;
            end else if (!succ_f_r && SW'(h_start) == blk_end) begin
              succ_f_r     <= 1'b1;
              succ_idx_r   <= h_idx;
              succ_pages_r <= h_pages;
            end
          end else if (!free_f_r) begin
            free_f_r   <= 1'b1;
            free_idx_r <= h_idx;
          end
          if (last_h) begin
            state_r <= S_MERGE;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_PRD;
          end
        end
        S_MERGE: begin
          // coalesce with neighbors, else take a free slot, else drop
          if (pred_ok) begin
            if (tri_ok) begin
              hv_r[succ_idx_r] <= 1'b0;
            end
          end else if (!succ_ok && free_f_r) begin
            hv_r[free_idx_r] <= 1'b1;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_addr_r   <= res_addr_r;
            out_pages_r  <= res_pages_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
